>>> design/sbde_pkg.sv
// Package for the sliding B-spline evaluator: constants, codes, cell types.
// No dependencies.
package sbde_pkg;
  localparam int Degree = 3;
  localparam int NPts = Degree + 1;
  localparam int CntW = $clog2(NPts + 1);
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef logic signed [47:0] val_t;  // Q.16 working value

  // round(2^32 / d) for d = 1..8; 0 for any other d
  function automatic logic [32:0] recip(input logic [3:0] d);
    logic [32:0] r;
    unique case (d)
      4'd1: r = 33'd4294967296;
      4'd2: r = 33'd2147483648;
      4'd3: r = 33'd1431655765;
      4'd4: r = 33'd1073741824;
      4'd5: r = 33'd858993459;
      4'd6: r = 33'd715827883;
      4'd7: r = 33'd613566757;
      4'd8: r = 33'd536870912;
      default: r = 33'd0;
    endcase
    return r;
  endfunction
endpackage

>>> design/sbde_cell.sv
// One window cell: holds a point and its Q.16 working value, shifts in from
// its higher-index neighbor. Depends on sbde_pkg.
module sbde_cell import sbde_pkg::*; (
  input  logic              clk_i,
  input  logic              load_i,   // load point from neighbor/input
  input  logic signed [15:0] pt_x_i,
  input  logic signed [15:0] pt_y_i,
  input  logic signed [15:0] pt_z_i,
  input  logic              init_i,   // copy point into working value
  input  logic              wr_i,     // write blended value
  input  logic [1:0]        wr_c_i,
  input  val_t              wr_val_i,
  output logic signed [15:0] pt_x_o,
  output logic signed [15:0] pt_y_o,
  output logic signed [15:0] pt_z_o,
  output val_t              v_x_o,
  output val_t              v_y_o,
  output val_t              v_z_o
);
  logic signed [15:0] x_q, y_q, z_q;
  val_t vx_q, vy_q, vz_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= pt_x_i;
      y_q <= pt_y_i;
      z_q <= pt_z_i;
    end
    if (init_i) begin
      vx_q <= {{16{x_q[15]}}, x_q, 16'd0};
      vy_q <= {{16{y_q[15]}}, y_q, 16'd0};
      vz_q <= {{16{z_q[15]}}, z_q, 16'd0};
    end else if (wr_i) begin
      if (wr_c_i == 2'd0) vx_q <= wr_val_i;
      if (wr_c_i == 2'd1) vy_q <= wr_val_i;
      if (wr_c_i == 2'd2) vz_q <= wr_val_i;
    end
  end

  assign pt_x_o = x_q;
  assign pt_y_o = y_q;
  assign pt_z_o = z_q;
  assign v_x_o = vx_q;
  assign v_y_o = vy_q;
  assign v_z_o = vz_q;
endmodule

>>> design/sliding_bspline_deboor_evaluator.sv
// Sliding-window uniform B-spline evaluator (de Boor), top level.
// Push/clear/unused, or evaluate on a partial window: DONE, then strobe. Full
// evaluate: INIT, then weight, two products, round per blend, over 3 coords x
// Degree*(Degree+1)/2 blends, then DONE, strobe; one multiplier pair is shared.
// busy is high from an accepted start until strobe rises; receiver cannot stall.
// rst_ni async clears count, sequencer and strobe; window contents undefined.
module sliding_bspline_deboor_evaluator import sbde_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  input  logic [16:0]       param_u_i,
  output logic              strobe,
  output logic              window_full_o,
  output logic              result_valid_o,
  output logic signed [31:0] curve_x_o,
  output logic signed [31:0] curve_y_o,
  output logic signed [31:0] curve_z_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_WGT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam int JW = $clog2(NPts);

  logic [2:0] st_q, st_d;
  logic [CntW-1:0] cnt_q;
  logic [1:0] cmd_q;
  logic [16:0] u_q;
  logic [JW-1:0] k_q, j_q;
  logic [1:0] c_q;
  logic [16:0] t_q;
  logic signed [65:0] pa_q, pb_q;
  val_t wr_val;
  logic wr;
  logic full;
  logic strobe_q, valid_q, fullo_q;
  logic signed [31:0] rx_q, ry_q, rz_q;

  logic signed [15:0] px [NPts], py [NPts], pz [NPts];
  val_t vx [NPts], vy [NPts], vz [NPts];
  logic signed [15:0] inx [NPts], iny [NPts], inz [NPts];
  logic ld [NPts];
  logic accept;

  assign accept = start && !busy;
  assign full = (cnt_q == CntW'(NPts));
  assign busy = (st_q != S_IDLE);

  // point loading: append at count, or shift down the chain when full
  for (genvar i = 0; i < NPts; i++) begin : g_cell
    always_comb begin
      if (full && i < Degree) begin
        inx[i] = px[(i + 1) % NPts];
        iny[i] = py[(i + 1) % NPts];
        inz[i] = pz[(i + 1) % NPts];
      end else begin
        inx[i] = point_x_i;
        iny[i] = point_y_i;
        inz[i] = point_z_i;
      end
      ld[i] = accept && command_i == CMD_PUSH &&
              (full || cnt_q == CntW'(i));
    end
    sbde_cell u_cell (
      .clk_i, .load_i(ld[i]), .pt_x_i(inx[i]), .pt_y_i(iny[i]), .pt_z_i(inz[i]),
      .init_i(st_q == S_INIT), .wr_i(wr && j_q == JW'(i)), .wr_c_i(c_q),
      .wr_val_i(wr_val), .pt_x_o(px[i]), .pt_y_o(py[i]), .pt_z_o(pz[i]),
      .v_x_o(vx[i]), .v_y_o(vy[i]), .v_z_o(vz[i])
    );
  end

  // weight: t = (num*R + 2^31) >> 32, saturated
  logic [3:0] d_w;
  logic [19:0] num_w;
  logic [53:0] prod_w;
  logic [21:0] t_w;
  assign d_w = 4'(Degree - int'(k_q));
  assign num_w = 20'(u_q) + 20'((Degree - int'(j_q))) * 20'd65536;
  assign prod_w = 54'(num_w) * 54'(recip(d_w)) + 54'h80000000;
  assign t_w = prod_w[53:32];

  val_t cur, prv;
  always_comb begin
    unique case (c_q)
      2'd0: begin cur = vx[j_q]; prv = vx[j_q - 1'b1]; end
      2'd1: begin cur = vy[j_q]; prv = vy[j_q - 1'b1]; end
      default: begin cur = vz[j_q]; prv = vz[j_q - 1'b1]; end
    endcase
  end

  logic signed [65:0] sum_w;
  assign sum_w = pa_q + pb_q + 66'sd32768;
  assign wr_val = val_t'(sum_w >>> 16);
  assign wr = (st_q == S_SUM);

  // k_q holds level-1 (0..Degree-1), j_q position
  logic last_blend;
  assign last_blend = (c_q == 2'd2) && (j_q == JW'(int'(k_q) + 1)) &&
                      (k_q == JW'(Degree - 1));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (accept) st_d = (command_i == CMD_EVAL && full) ? S_INIT : S_DONE;
      S_INIT: st_d = S_WGT;
      S_WGT:  st_d = S_MUL;
      S_MUL:  st_d = S_SUM;
      S_SUM:  st_d = last_blend ? S_DONE : S_WGT;
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      st_q <= st_d;
      strobe_q <= (st_q == S_DONE);
      if (accept && command_i == CMD_CLEAR) cnt_q <= '0;
      else if (accept && command_i == CMD_PUSH && !full) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      u_q <= (param_u_i > ONE_Q16) ? ONE_Q16 : param_u_i;
    end
    if (st_q == S_INIT) begin
      k_q <= '0;
      j_q <= JW'(Degree);
      c_q <= 2'd0;
    end
    if (st_q == S_WGT) t_q <= (t_w > 22'(ONE_Q16)) ? ONE_Q16 : t_w[16:0];
    if (st_q == S_MUL) begin
      pa_q <= 66'(cur) * $signed({1'b0, t_q});
      pb_q <= 66'(prv) * $signed({1'b0, ONE_Q16 - t_q});
    end
    if (st_q == S_SUM && !last_blend) begin
      if (c_q != 2'd2) c_q <= c_q + 1'b1;
      else begin
        c_q <= 2'd0;
        if (j_q == JW'(int'(k_q) + 1)) begin
          k_q <= k_q + 1'b1;
          j_q <= JW'(Degree);
        end else j_q <= j_q - 1'b1;
      end
    end
    if (st_q == S_DONE) begin
      fullo_q <= full;
      valid_q <= (cmd_q == CMD_EVAL) && full;
      if ((cmd_q == CMD_EVAL) && full) begin
        rx_q <= vx[Degree][31:0];
        ry_q <= vy[Degree][31:0];
        rz_q <= vz[Degree][31:0];
      end else begin
        rx_q <= '0;
        ry_q <= '0;
        rz_q <= '0;
      end
    end
  end

  assign strobe = strobe_q;
  assign window_full_o = fullo_q;
  assign result_valid_o = valid_q;
  assign curve_x_o = rx_q;
  assign curve_y_o = ry_q;
  assign curve_z_o = rz_q;
endmodule

>>> design/sbde_checker.sv
// Port-level checks for the sliding B-spline evaluator; bound to the top.
// Depends on sliding_bspline_deboor_evaluator ports only.
module sbde_props (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic result_valid_o,
  input logic window_full_o,
  input logic signed [31:0] curve_x_o
);
  a_strobe_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> !busy) else $error("strobe while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("no busy after accept");
  a_valid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && result_valid_o |-> window_full_o) else $error("valid on partial window");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !result_valid_o |-> curve_x_o == 32'sd0) else $error("nonzero curve");
endmodule

bind sliding_bspline_deboor_evaluator sbde_props u_sbde_props (
  .clk_i, .rst_ni, .start, .busy, .strobe, .result_valid_o, .window_full_o, .curve_x_o
);

>>> sim/sbde_checker.sv
// Checker for the sliding B-spline evaluator: watches start/busy and the result
// strobe, predicts each result from its own window copy, and counts mismatches.
// Depends on sbde_pkg.
module sbde_checker import sbde_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         command_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  input  logic [16:0]        param_u_i,
  input  logic               strobe,
  input  logic               window_full_o,
  input  logic               result_valid_o,
  input  logic signed [31:0] curve_x_o,
  input  logic signed [31:0] curve_y_o,
  input  logic signed [31:0] curve_z_o,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               full;
    logic               valid;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } curve_res_t;

  curve_res_t          expected_q[$];
  logic signed [15:0]  win_pts[NPts][3];
  int unsigned         n_pts;

  // round(2^32 / d) for d = 1..7; any other d gives the value for 8
  function automatic longint unsigned inv_of(int d);
    case (d)
      1: return 64'd4294967296;
      2: return 64'd2147483648;
      3: return 64'd1431655765;
      4: return 64'd1073741824;
      5: return 64'd858993459;
      6: return 64'd715827883;
      7: return 64'd613566757;
      default: return 64'd536870912;
    endcase
  endfunction

  function automatic logic signed [31:0] deboor_coord(int c, logic [16:0] u_in);
    longint p[NPts];
    longint unsigned uu, num, t;
    longint s;
    uu = (u_in > ONE_Q16) ? 65536 : u_in;
    for (int i = 0; i < NPts; i++) p[i] = longint'(win_pts[i][c]) * 65536;
    for (int k = 1; k <= Degree; k++) begin
      for (int j = Degree; j >= k; j--) begin
        num = uu + longint'(Degree - j) * 65536;
        t = (num * inv_of(Degree - k + 1) + 64'h8000_0000) >> 32;
        if (t > 65536) t = 65536;
        s = p[j] * longint'(t) + p[j-1] * (65536 - longint'(t)) + 32768;
        p[j] = s >>> 16;
      end
    end
    return p[Degree][31:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    curve_res_t r, e;
    if (!rst_ni) begin
      n_pts = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (strobe) begin
        r = '{window_full_o, result_valid_o, curve_x_o, curve_y_o, curve_z_o};
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = expected_q.pop_front();
          if (r.full !== e.full) report_mismatch("window_full", r.full, e.full);
          if (r.valid !== e.valid) report_mismatch("result_valid", r.valid, e.valid);
          if (r.cx !== e.cx) report_mismatch("curve_x", r.cx, e.cx);
          if (r.cy !== e.cy) report_mismatch("curve_y", r.cy, e.cy);
          if (r.cz !== e.cz) report_mismatch("curve_z", r.cz, e.cz);
        end
      end
      if (start && !busy) begin
        e = '0;
        case (command_i)
          CMD_PUSH: begin
            if (n_pts < NPts) begin
              n_pts++;
            end else begin
              for (int i = 0; i < Degree; i++) win_pts[i] = win_pts[i+1];
            end
            win_pts[n_pts-1] = '{point_x_i, point_y_i, point_z_i};
          end
          CMD_CLEAR: n_pts = 0;
          CMD_EVAL: begin
            if (n_pts == NPts) begin
              e.valid = 1'b1;
              e.cx = deboor_coord(0, param_u_i);
              e.cy = deboor_coord(1, param_u_i);
              e.cz = deboor_coord(2, param_u_i);
            end
          end
          default: ;
        endcase
        e.full = (n_pts == NPts);
        expected_q.push_back(e);
      end
    end
    pending_count = expected_q.size();
  end
endmodule

>>> sim/tb_top.sv
// Testbench top for the sliding B-spline evaluator: clock, reset, directed and
// random command items, verdict. Depends on sbde_pkg, the block and sbde_checker.
module tb_top import sbde_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         command_i = CMD_CLEAR;
  logic signed [15:0] point_x_i = '0;
  logic signed [15:0] point_y_i = '0;
  logic signed [15:0] point_z_i = '0;
  logic [16:0]        param_u_i = '0;
  logic               strobe, window_full_o, result_valid_o;
  logic signed [31:0] curve_x_o, curve_y_o, curve_z_o;
  int                 fail_count, pending_count;
  int unsigned        cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sliding_bspline_deboor_evaluator dut (.*);
  sbde_checker chk (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("** sliding_bspline_deboor_evaluator: FAILED **");
      $finish;
    end
  end

  // one item: drive, hold until taken, drop start
  task automatic send_item(logic [1:0] cmd, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z, logic [16:0] u);
    start <= 1'b1;
    command_i <= cmd;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    param_u_i <= u;
    do @(posedge clk_i); while (busy);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rnd_param();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return ONE_Q16;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic push_rnd();
    send_item(CMD_PUSH, rnd_coord(), rnd_coord(), rnd_coord(), 17'($urandom));
  endtask

  initial begin
    int unsigned r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // evaluate on empty, unused code, then fill with extreme points
    send_item(CMD_EVAL, '0, '0, '0, ONE_Q16);
    send_item(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff, 17'h1ffff);
    send_item(CMD_PUSH, 16'h7fff, 16'h8000, 16'h0000, '0);
    send_item(CMD_PUSH, 16'h8000, 16'h7fff, 16'hffff, '0);
    send_item(CMD_EVAL, '0, '0, '0, 17'd32768);
    send_item(CMD_PUSH, 16'h7fff, 16'h8000, 16'h0001, '0);
    send_item(CMD_PUSH, 16'h8000, 16'h7fff, 16'h7fff, '0);
    send_item(CMD_EVAL, '0, '0, '0, 17'd0);
    send_item(CMD_EVAL, '0, '0, '0, ONE_Q16);
    send_item(CMD_EVAL, '0, '0, '0, 17'h1ffff);
    send_item(CMD_EVAL, '0, '0, '0, 17'd1);
    send_item(CMD_PUSH, 16'h8000, 16'h8000, 16'h8000, '0);
    send_item(CMD_EVAL, '0, '0, '0, 17'd65535);
    send_item(CMD_UNUSED, '0, '0, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_EVAL, '0, '0, '0, 17'd100);
    // wait for every result before going random
    while (pending_count != 0) @(posedge clk_i);
    for (int n = 0; n < 1200; n++) begin
      if (n < 1100 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 45) push_rnd();
      else if (r < 90) send_item(CMD_EVAL, rnd_coord(), rnd_coord(), rnd_coord(),
                                 rnd_param());
      else if (r < 95) send_item(CMD_CLEAR, rnd_coord(), '0, '0, rnd_param());
      else send_item(CMD_UNUSED, rnd_coord(), rnd_coord(), rnd_coord(), rnd_param());
    end
    while (pending_count != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("** sliding_bspline_deboor_evaluator: PASSED **");
    else
      $display("** sliding_bspline_deboor_evaluator: FAILED **");
    $finish;
  end
endmodule
